// ===== src/ptil_pkg.sv =====
// ----------------------------------------------------------------------------
// ptil_pkg
// Shared types and constants for the point-in-triangle locator.
// ----------------------------------------------------------------------------
package ptil_pkg;

  localparam int TABLE_DEPTH_DEF    = 1024;
  localparam int VERTEX_ID_BITS_DEF = 16;

  localparam int COORD_W  = 16;  // signed Q5.10
  localparam int VID_W    = 16;  // vertex id field width on the ports
  localparam int OPCODE_W = 2;

  typedef enum logic [OPCODE_W-1:0] {
    OP_APPEND = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2
  } opcode_t;

  // controller -> datapath
  typedef struct packed {
    logic append;    // write triangle at the fill pointer
    logic clear;     // empty the table
    logic start;     // latch query point, rewind scan, clear result
    logic issue;     // read the next entry and advance
    logic flush;     // drop everything in the compare pipeline
    logic load_out;  // move the result into the output register
  } ptil_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;       // table holds TABLE_DEPTH triangles
    logic empty;      // table holds none
    logic last_addr;  // scan pointer is at the last stored entry
    logic hit;        // last compare stage holds a containing triangle
    logic busy;       // earlier compare stages still hold entries
    logic out_free;   // output register can take a result this cycle
  } ptil_status_t;

endpackage

// ===== src/ptil_if.sv =====
// ----------------------------------------------------------------------------
// ptil_if
// Request and response channels of the point-in-triangle locator.
// ----------------------------------------------------------------------------
interface ptil_req_if
  import ptil_pkg::*;
();

  logic                       valid;
  logic                       ready;
  logic [OPCODE_W-1:0]        opcode;
  logic signed [COORD_W-1:0]  ax;
  logic signed [COORD_W-1:0]  ay;
  logic signed [COORD_W-1:0]  bx;
  logic signed [COORD_W-1:0]  by;
  logic signed [COORD_W-1:0]  cx;
  logic signed [COORD_W-1:0]  cy;
  logic [VID_W-1:0]           vid_a;
  logic [VID_W-1:0]           vid_b;
  logic [VID_W-1:0]           vid_c;
  logic signed [COORD_W-1:0]  px;
  logic signed [COORD_W-1:0]  py;

  modport source (
    output valid, opcode, ax, ay, bx, by, cx, cy, vid_a, vid_b, vid_c, px, py,
    input  ready
  );
  modport sink (
    input  valid, opcode, ax, ay, bx, by, cx, cy, vid_a, vid_b, vid_c, px, py,
    output ready
  );
endinterface

interface ptil_rsp_if
  import ptil_pkg::*;
();

  logic             valid;
  logic             ready;
  logic             found;
  logic [VID_W-1:0] hit_vid_a;
  logic [VID_W-1:0] hit_vid_b;
  logic [VID_W-1:0] hit_vid_c;

  modport source (
    output valid, found, hit_vid_a, hit_vid_b, hit_vid_c,
    input  ready
  );
  modport sink (
    input  valid, found, hit_vid_a, hit_vid_b, hit_vid_c,
    output ready
  );
endinterface

// ===== src/point_in_triangle_locator_unit.sv =====
// ----------------------------------------------------------------------------
// point_in_triangle_locator_unit
// Triangle table with append, clear and first-hit point location query.
// ----------------------------------------------------------------------------
//
//  channel | dir | transfer when        | carries
//  --------+-----+----------------------+------------------------------------
//  req     | in  | req.valid&req.ready  | opcode, corners, vertex ids, point
//  rsp     | out | rsp.valid&rsp.ready  | found, hit_vid_a/b/c (queries only)
//
//  Appends and clears are taken back to back. A query on a miss holds
//  the input through the accept cycle, one table read per cycle, the
//  drain of the compare pipeline, and the hand-off. An early hit ends
//  the scan sooner; an empty table goes straight to the hand-off.
//  The scan rate is set by the single read port of each store.
//  Reset (rst, synchronous) empties the table; store contents are not
//  cleared, and entries at or above the fill count are never scanned.
//  A finished result waits in the output register; appends and clears keep
//  being taken meanwhile, and a new query stalls only at its hand-off.
//
module point_in_triangle_locator_unit
  import ptil_pkg::*;
#(
  parameter int TABLE_DEPTH    = TABLE_DEPTH_DEF,
  parameter int VERTEX_ID_BITS = VERTEX_ID_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  ptil_req_if.sink   req,
  ptil_rsp_if.source rsp
);

  ptil_cmd_t    cmd;
  ptil_status_t sts;

  // sequencer: owns req.ready and all scan sequencing
  ptil_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .opcode    (req.opcode),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // stores, edge-sign compare pipeline and output register
  ptil_datapath #(
    .TABLE_DEPTH    (TABLE_DEPTH),
    .VERTEX_ID_BITS (VERTEX_ID_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .ax        (req.ax),
    .ay        (req.ay),
    .bx        (req.bx),
    .by        (req.by),
    .cx        (req.cx),
    .cy        (req.cy),
    .vid_a     (req.vid_a),
    .vid_b     (req.vid_b),
    .vid_c     (req.vid_c),
    .px        (req.px),
    .py        (req.py),
    .out_ready (rsp.ready),
    .out_valid (rsp.valid),
    .found     (rsp.found),
    .hit_vid_a (rsp.hit_vid_a),
    .hit_vid_b (rsp.hit_vid_b),
    .hit_vid_c (rsp.hit_vid_c)
  );

endmodule

// ===== src/ptil_ram.sv =====
// ----------------------------------------------------------------------------
// ptil_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ptil_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/ptil_datapath.sv =====
// ----------------------------------------------------------------------------
// ptil_datapath
// Triangle stores, scan pointer, edge-sign compare pipeline and result regs.
// ----------------------------------------------------------------------------
module ptil_datapath
  import ptil_pkg::*;
#(
  parameter int TABLE_DEPTH    = TABLE_DEPTH_DEF,
  parameter int VERTEX_ID_BITS = VERTEX_ID_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  ptil_cmd_t                 cmd,
  output ptil_status_t              sts,
  input  logic signed [COORD_W-1:0] ax,
  input  logic signed [COORD_W-1:0] ay,
  input  logic signed [COORD_W-1:0] bx,
  input  logic signed [COORD_W-1:0] by,
  input  logic signed [COORD_W-1:0] cx,
  input  logic signed [COORD_W-1:0] cy,
  input  logic [VID_W-1:0]          vid_a,
  input  logic [VID_W-1:0]          vid_b,
  input  logic [VID_W-1:0]          vid_c,
  input  logic signed [COORD_W-1:0] px,
  input  logic signed [COORD_W-1:0] py,
  input  logic                      out_ready,
  output logic                      out_valid,
  output logic                      found,
  output logic [VID_W-1:0]          hit_vid_a,
  output logic [VID_W-1:0]          hit_vid_b,
  output logic [VID_W-1:0]          hit_vid_c
);

  localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int SVID_W = (VERTEX_ID_BITS < VID_W) ? VERTEX_ID_BITS : VID_W;
  localparam int AB_W   = 4 * COORD_W;
  localparam int C_W    = 2 * COORD_W;
  localparam int VS_W   = 3 * SVID_W;
  localparam int DF_W   = COORD_W + 1;
  localparam int PR_W   = 2 * DF_W;
  localparam int CR_W   = PR_W + 1;
  localparam int SM_W   = CR_W + 1;

  // table fill and scan pointer
  logic [CNT_W-1:0]  count;
  logic [ADDR_W-1:0] addr;
  logic signed [COORD_W-1:0] qx, qy;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.clear) begin
      count <= '0;
    end else if (cmd.append) begin
      count <= count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      addr <= '0;
      qx   <= px;
      qy   <= py;
    end else if (cmd.issue) begin
      addr <= addr + 1'b1;
    end
  end

  // stores
  logic [AB_W-1:0] ab_q;
  logic [C_W-1:0]  c_q;
  logic [VS_W-1:0] vid_q;

  ptil_ram #(.WIDTH(AB_W), .DEPTH(TABLE_DEPTH)) u_ab_ram (
    .clk   (clk),
    .we    (cmd.append),
    .waddr (count[ADDR_W-1:0]),
    .wdata ({by, bx, ay, ax}),
    .raddr (addr),
    .rdata (ab_q)
  );

  ptil_ram #(.WIDTH(C_W), .DEPTH(TABLE_DEPTH)) u_c_ram (
    .clk   (clk),
    .we    (cmd.append),
    .waddr (count[ADDR_W-1:0]),
    .wdata ({cy, cx}),
    .raddr (addr),
    .rdata (c_q)
  );

  ptil_ram #(.WIDTH(VS_W), .DEPTH(TABLE_DEPTH)) u_vid_ram (
    .clk   (clk),
    .we    (cmd.append),
    .waddr (count[ADDR_W-1:0]),
    .wdata ({vid_c[SVID_W-1:0], vid_b[SVID_W-1:0], vid_a[SVID_W-1:0]}),
    .raddr (addr),
    .rdata (vid_q)
  );

  // stage valids: v1 RAM data, v2 differences, v3 products, v4 cross products
  logic v1, v2, v3, v4;

  always_ff @(posedge clk) begin
    if (rst || cmd.flush) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  logic [COORD_W-1:0] x0, y0, x1, y1, x2, y2;
  assign x0 = ab_q[COORD_W-1:0];
  assign y0 = ab_q[2*COORD_W-1:COORD_W];
  assign x1 = ab_q[3*COORD_W-1:2*COORD_W];
  assign y1 = ab_q[4*COORD_W-1:3*COORD_W];
  assign x2 = c_q[COORD_W-1:0];
  assign y2 = c_q[2*COORD_W-1:COORD_W];

  // edge differences
  logic signed [DF_W-1:0] s_ux, s_py, s_uy, s_px;
  logic signed [DF_W-1:0] t_ux, t_py, t_uy, t_px;
  logic signed [DF_W-1:0] d_ux, d_py, d_uy, d_px;
  logic [VS_W-1:0] vid2, vid3, vid4;

  always_ff @(posedge clk) begin
    s_ux <= {x0[COORD_W-1], x0} - {x2[COORD_W-1], x2};
    s_py <= {qy[COORD_W-1], qy} - {y2[COORD_W-1], y2};
    s_uy <= {y0[COORD_W-1], y0} - {y2[COORD_W-1], y2};
    s_px <= {qx[COORD_W-1], qx} - {x2[COORD_W-1], x2};
    t_ux <= {x1[COORD_W-1], x1} - {x0[COORD_W-1], x0};
    t_py <= {qy[COORD_W-1], qy} - {y0[COORD_W-1], y0};
    t_uy <= {y1[COORD_W-1], y1} - {y0[COORD_W-1], y0};
    t_px <= {qx[COORD_W-1], qx} - {x0[COORD_W-1], x0};
    d_ux <= {x2[COORD_W-1], x2} - {x1[COORD_W-1], x1};
    d_py <= {qy[COORD_W-1], qy} - {y1[COORD_W-1], y1};
    d_uy <= {y2[COORD_W-1], y2} - {y1[COORD_W-1], y1};
    d_px <= {qx[COORD_W-1], qx} - {x1[COORD_W-1], x1};
    vid2 <= vid_q;
  end

  // products, exact; operands sign-extended to the product width
  logic signed [PR_W-1:0] s_p, s_q, t_p, t_q, d_p, d_q;

  always_ff @(posedge clk) begin
    s_p  <= PR_W'(s_ux) * PR_W'(s_py);
    s_q  <= PR_W'(s_uy) * PR_W'(s_px);
    t_p  <= PR_W'(t_ux) * PR_W'(t_py);
    t_q  <= PR_W'(t_uy) * PR_W'(t_px);
    d_p  <= PR_W'(d_ux) * PR_W'(d_py);
    d_q  <= PR_W'(d_uy) * PR_W'(d_px);
    vid3 <= vid2;
  end

  // cross products
  logic [CR_W-1:0] s_cr, t_cr, d_cr;

  always_ff @(posedge clk) begin
    s_cr <= {s_p[PR_W-1], s_p} - {s_q[PR_W-1], s_q};
    t_cr <= {t_p[PR_W-1], t_p} - {t_q[PR_W-1], t_q};
    d_cr <= {d_p[PR_W-1], d_p} - {d_q[PR_W-1], d_q};
    vid4 <= vid3;
  end

  // sign tests
  logic [SM_W-1:0] st_sum;
  logic            s_neg, t_neg, d_neg, s_zero, t_zero, d_zero, sum_le0;
  logic            skip, inside_tri;

  assign st_sum     = {s_cr[CR_W-1], s_cr} + {t_cr[CR_W-1], t_cr};
  assign s_neg      = s_cr[CR_W-1];
  assign t_neg      = t_cr[CR_W-1];
  assign d_neg      = d_cr[CR_W-1];
  assign s_zero     = (s_cr == '0);
  assign t_zero     = (t_cr == '0);
  assign d_zero     = (d_cr == '0);
  assign sum_le0    = st_sum[SM_W-1] || (st_sum == '0);
  assign skip       = (s_neg != t_neg) && !s_zero && !t_zero;
  assign inside_tri = !skip && (d_zero || (d_neg == sum_le0));

  // query result
  logic              res_found;
  logic [VS_W-1:0]   res_vid;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      res_found <= 1'b0;
      res_vid   <= '0;
    end else if (v4 && inside_tri) begin
      res_found <= 1'b1;
      res_vid   <= vid4;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      found     <= res_found;
      hit_vid_a <= VID_W'(res_vid[SVID_W-1:0]);
      hit_vid_b <= VID_W'(res_vid[2*SVID_W-1:SVID_W]);
      hit_vid_c <= VID_W'(res_vid[3*SVID_W-1:2*SVID_W]);
    end
  end

  assign sts.full      = (count == CNT_W'(TABLE_DEPTH));
  assign sts.empty     = (count == '0);
  assign sts.last_addr = (CNT_W'(addr) == count - 1'b1);
  assign sts.hit       = v4 && inside_tri;
  assign sts.busy      = v1 || v2 || v3;
  assign sts.out_free  = !out_valid || out_ready;

endmodule

// ===== src/ptil_ctrl.sv =====
// ----------------------------------------------------------------------------
// ptil_ctrl
// Sequencer: decodes requests, runs the table scan, hands off the result.
// ----------------------------------------------------------------------------
module ptil_ctrl
  import ptil_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  logic [OPCODE_W-1:0] opcode,
  output logic                req_ready,
  input  ptil_status_t        sts,
  output ptil_cmd_t           cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_DRAIN,
    S_FINISH
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          unique case (opcode)
            OP_APPEND: cmd.append = !sts.full;
            OP_CLEAR:  cmd.clear  = 1'b1;
            OP_QUERY: begin
              cmd.start  = 1'b1;
              state_next = sts.empty ? S_FINISH : S_ISSUE;
            end
            default: ;  // unused opcode, dropped
          endcase
        end
      end
      S_ISSUE: begin
        cmd.issue = 1'b1;
        if (sts.hit) begin
          cmd.flush  = 1'b1;
          state_next = S_FINISH;
        end else if (sts.last_addr) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (sts.hit) begin
          cmd.flush  = 1'b1;
          state_next = S_FINISH;
        end else if (!sts.busy) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      req_ready <= 1'b1;
    end else begin
      state     <= state_next;
      req_ready <= (state_next == S_IDLE);
    end
  end

endmodule
